>>> rtl/pulse_channel_with_sweep_defines.svh
// Assertion shorthands shared by the channel RTL.
// Each one expects clk and arst_n in the scope where it is used.
`ifndef PULSE_CHANNEL_WITH_SWEEP_DEFINES_SVH
`define PULSE_CHANNEL_WITH_SWEEP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define PCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pcs_pkg.sv
package pcs_pkg;

	// Action codes of an input word
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Channel register byte indexes
	localparam logic [2:0] REG_SWEEP    = 3'd0;
	localparam logic [2:0] REG_DUTY_LEN = 3'd1;
	localparam logic [2:0] REG_ENV      = 3'd2;
	localparam logic [2:0] REG_FREQ_LO  = 3'd3;
	localparam logic [2:0] REG_FREQ_HI  = 3'd4;
	localparam int         NUM_REGS     = 5;

	// Configuration register indexes
	localparam logic CFG_MASTER_ENABLE = 1'b0;

	// Timer constants, in 1048576 Hz ticks
	localparam logic [16:0] ACC_MAX   = 17'h1FFFF;
	localparam logic [16:0] LEN_TICKS = 17'd4096;
	localparam logic [6:0]  LEN_LIMIT = 7'd64;
	localparam logic [11:0] FREQ_MAX  = 12'd2047;
	localparam logic [11:0] DUTY_SPAN = 12'd2048;
	localparam logic [3:0]  VOL_MAX   = 4'd15;

	typedef struct packed {
		logic       action;
		logic [7:0] tick_cycles;
		logic [2:0] reg_index;
		logic [7:0] write_data;
	} pcs_item_t;

	typedef struct packed {
		logic       channel_on;
		logic       duty_bit;
		logic [3:0] level;
		logic [2:0] duty_position;
	} pcs_result_t;

	typedef struct packed {
		logic [NUM_REGS-1:0][7:0] regs;
		logic                     enabled;
		logic [7:0]               pattern;
		logic [2:0]               step;
		logic [3:0]               volume;
		logic [6:0]               len_count;
		logic                     len_on;
		logic                     env_up;
		logic [2:0]               env_rate;
		logic [2:0]               sweep_rate;
		logic                     sweep_down;
		logic [2:0]               sweep_shift;
		logic [10:0]              freq;
		logic [16:0]              len_acc;
		logic [16:0]              sweep_acc;
		logic [16:0]              duty_acc;
		logic [16:0]              env_acc;
	} pcs_state_t;

	// Eight-step waveform for each duty code
	function automatic logic [7:0] duty_wave(input logic [1:0] sel);
		logic [7:0] w;
		case (sel)
			2'd0: w = 8'h01;
			2'd1: w = 8'h03;
			2'd2: w = 8'h0F;
			2'd3: w = 8'hFC;
			default: w = 8'h01;
		endcase
		return w;
	endfunction

	// Add ticks to an accumulator, holding at the top
	function automatic logic [16:0] acc_add(input logic [16:0] a, input logic [7:0] d);
		logic [17:0] s;
		s = {1'b0, a} + {10'b0, d};
		return s[17] ? ACC_MAX : s[16:0];
	endfunction

endpackage

>>> rtl/pcs_ifs.sv
// Input word channel: one tick count or one register write
interface pcs_cmd_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] tick_cycles;
	logic [2:0] reg_index;
	logic [7:0] write_data;

	modport source (output valid, action, tick_cycles, reg_index, write_data, input ready);
	modport sink (input valid, action, tick_cycles, reg_index, write_data, output ready);
endinterface

// Result word channel: channel status after each input word
interface pcs_sample_if;
	logic       valid;
	logic       ready;
	logic       channel_on;
	logic       duty_bit;
	logic [3:0] level;
	logic [2:0] duty_position;

	modport source (output valid, channel_on, duty_bit, level, duty_position, input ready);
	modport sink (input valid, channel_on, duty_bit, level, duty_position, output ready);
endinterface

>>> rtl/pcs_chan.sv
`include "pulse_channel_with_sweep_defines.svh"

module pcs_chan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                master_en,
	input  pcs_pkg::pcs_item_t   item,
	output pcs_pkg::pcs_result_t result
);
	import pcs_pkg::*;

	pcs_state_t  st_q;
	pcs_state_t  nxt;
	logic        live;
	logic        wave_bit;
	logic [15:0] sweep_span;
	logic [16:0] env_span;
	logic [11:0] duty_target;
	logic [10:0] sweep_off;
	logic [11:0] freq_sum;
	logic [7:0]  r0, r1, r2, r4;

	// Compute the state after the current word
	always_comb begin
		nxt          = st_q;
		live         = 1'b1;
		sweep_span   = {st_q.sweep_rate, 13'b0};
		env_span     = {st_q.env_rate, 14'b0};
		sweep_off    = '0;
		freq_sum     = '0;
		duty_target  = '0;
		r0           = '0;
		r1           = '0;
		r2           = '0;
		r4           = '0;

		if (fire && item.action == ACT_WRITE) begin
			if (item.reg_index <= REG_FREQ_HI) begin
				// store the byte, then decode all bytes
				for (int i = 0; i < NUM_REGS; i++) begin
					if (item.reg_index == 3'(i)) begin
						nxt.regs[i] = item.write_data;
					end
				end
				r0 = nxt.regs[REG_SWEEP];
				r1 = nxt.regs[REG_DUTY_LEN];
				r2 = nxt.regs[REG_ENV];
				r4 = nxt.regs[REG_FREQ_HI];
				if (r4[7]) begin
					nxt.enabled   = 1'b1;
					nxt.step      = '0;
					nxt.len_acc   = '0;
					nxt.sweep_acc = '0;
					nxt.duty_acc  = '0;
					nxt.env_acc   = '0;
					nxt.volume    = r2[7:4];
				end
				nxt.pattern     = duty_wave(r1[7:6]);
				nxt.len_on      = r4[6];
				nxt.len_count   = {1'b0, r1[5:0]};
				nxt.env_up      = r2[3];
				nxt.env_rate    = r2[2:0];
				nxt.sweep_rate  = r0[6:4];
				nxt.sweep_down  = r0[3];
				nxt.sweep_shift = r0[2:0];
				nxt.freq        = {r4[2:0], nxt.regs[REG_FREQ_LO]};
			end
		end else if (fire && master_en && st_q.enabled) begin
			// length timer
			if (st_q.len_on) begin
				nxt.len_acc = acc_add(st_q.len_acc, item.tick_cycles);
				if (nxt.len_acc >= LEN_TICKS) begin
					nxt.len_acc   = nxt.len_acc - LEN_TICKS;
					nxt.len_count = st_q.len_count + 7'd1;
					if (nxt.len_count >= LEN_LIMIT) begin
						nxt.enabled = 1'b0;
						live        = 1'b0;
					end
				end
			end

			// sweep timer
			if (live && st_q.sweep_rate != '0) begin
				nxt.sweep_acc = acc_add(st_q.sweep_acc, item.tick_cycles);
				if (nxt.sweep_acc >= {1'b0, sweep_span}) begin
					nxt.sweep_acc = nxt.sweep_acc - {1'b0, sweep_span};
					sweep_off     = st_q.freq >> st_q.sweep_shift;
					freq_sum      = {1'b0, st_q.freq} + {1'b0, sweep_off};
					if (st_q.sweep_down) begin
						nxt.freq = st_q.freq - sweep_off;
					end else if (freq_sum > FREQ_MAX) begin
						nxt.freq    = FREQ_MAX[10:0];
						nxt.enabled = 1'b0;
						live        = 1'b0;
					end else begin
						nxt.freq = freq_sum[10:0];
					end
				end
			end

			// duty step timer
			if (live) begin
				duty_target  = DUTY_SPAN - {1'b0, nxt.freq};
				nxt.duty_acc = acc_add(st_q.duty_acc, item.tick_cycles);
				if (nxt.duty_acc >= {5'b0, duty_target}) begin
					nxt.duty_acc = nxt.duty_acc - {5'b0, duty_target};
					nxt.step     = st_q.step + 3'd1;
				end
			end

			// envelope timer
			if (live && st_q.env_rate != '0) begin
				nxt.env_acc = acc_add(st_q.env_acc, item.tick_cycles);
				if (nxt.env_acc >= env_span) begin
					nxt.env_acc = nxt.env_acc - env_span;
					if (!st_q.env_up && st_q.volume != '0) begin
						nxt.volume = st_q.volume - 4'd1;
					end else if (st_q.env_up && st_q.volume < VOL_MAX) begin
						nxt.volume = st_q.volume + 4'd1;
					end
				end
			end
		end
	end

	// Form the result from the updated state
	always_comb begin
		wave_bit             = nxt.pattern[nxt.step];
		result.channel_on    = nxt.enabled;
		result.duty_bit      = wave_bit;
		result.level         = (nxt.enabled && wave_bit) ? nxt.volume : 4'd0;
		result.duty_position = nxt.step;
	end

	// Hold the channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	`PCS_ASSERT_NEXT(a_idle_tick_stable, fire && item.action == ACT_TICK && !master_en,
		$stable(st_q), "tick changed state with master enable low")
	`PCS_ASSERT_NEXT(a_tick_no_enable, fire && item.action == ACT_TICK && !st_q.enabled,
		!st_q.enabled, "tick enabled a disabled channel")
	`PCS_ASSERT_NOW(a_len_in_range, st_q.enabled, st_q.len_count < LEN_LIMIT,
		"enabled channel with expired length count")

endmodule

>>> rtl/pulse_channel_with_sweep.sv
// Pulse channel with frequency sweep. Words enter on cmd: a tick word advances the
// length, sweep, duty and envelope timers by tick_cycles ticks of 1048576 Hz; a write
// word stores one of the five channel bytes and re-decodes them all (a set trigger bit
// in byte 4 retriggers on every later write to bytes 0-4). Each word gives exactly one
// word on sample, the channel status after it. One word is taken per clock cycle
// unless sample.ready stalls the result register; a word waits in the input register
// while the combinational timer update feeds the result register, and the result
// register lets the next word be taken while a result waits. With the master enable
// bit low, tick words change nothing; the bit sits at APB addresses 0-3 (paddr[2] alone
// is decoded) and is to be written while the channel is idle; the block does not enforce it.
`include "pulse_channel_with_sweep_defines.svh"

module pulse_channel_with_sweep (
	input  logic        clk,
	input  logic        arst_n,
	pcs_cmd_if.sink     cmd,
	pcs_sample_if.source sample,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pcs_pkg::*;

	logic        master_en_q;
	logic        cfg_wr;
	logic        valid_s1;
	pcs_item_t   item_s1;
	logic        out_valid_q;
	pcs_result_t res_q;
	pcs_result_t res_d;
	logic        advance;
	logic        fire;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_MASTER_ENABLE);
	assign prdata = (paddr[2] == CFG_MASTER_ENABLE) ? {31'b0, master_en_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_en_q <= 1'b0;
		end else if (cfg_wr) begin
			master_en_q <= pwdata[0];
		end
	end

	// Pipeline flow: advance when the result register is free or being drained
	assign advance   = !out_valid_q || sample.ready;
	assign fire      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= '{action: cmd.action, tick_cycles: cmd.tick_cycles,
				reg_index: cmd.reg_index, write_data: cmd.write_data};
		end
	end

	pcs_chan u_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.master_en (master_en_q),
		.item      (item_s1),
		.result    (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign sample.valid         = out_valid_q;
	assign sample.channel_on    = res_q.channel_on;
	assign sample.duty_bit      = res_q.duty_bit;
	assign sample.level         = res_q.level;
	assign sample.duty_position = res_q.duty_position;

	`PCS_ASSERT_NEXT(a_cmd_to_s1, cmd.valid && cmd.ready, valid_s1,
		"accepted word missing from input register")
	`PCS_ASSERT_NEXT(a_s1_to_out, fire, out_valid_q,
		"processed word missing from result register")
	`PCS_ASSERT_NOW(a_level_gated, out_valid_q && res_q.level != 4'd0,
		res_q.channel_on && res_q.duty_bit, "level set while channel off or duty low")

endmodule

>>> test/pcs_checker.sv
`timescale 1ns / 1ps
module pcs_checker (
	input  logic        clk,
	input  logic        arst_n,
	pcs_cmd_if          cmd,
	pcs_sample_if       sample,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          outstanding,
	output int          checked,
	output int          writes_seen,
	output int          ticks_seen,
	output int          length_stops,
	output int          sweep_stops
);
	import pcs_pkg::*;

	localparam logic [16:0] SWEEP_UNIT = 17'd8192;
	localparam logic [16:0] ENV_UNIT   = 17'd16384;
	localparam int          PRINT_CAP  = 50;

	// Channel copy kept by the checker
	logic        master_on;
	logic [7:0]  chan_bytes [NUM_REGS];
	logic        on;
	logic [7:0]  wave;
	logic [2:0]  step;
	logic [3:0]  vol;
	logic [6:0]  len_cnt;
	logic        len_en;
	logic        env_up;
	logic [2:0]  env_rate;
	logic [2:0]  sw_pace;
	logic        sw_down;
	logic [2:0]  sw_shift;
	logic [10:0] freq;
	logic [16:0] len_acc;
	logic [16:0] sw_acc;
	logic [16:0] duty_acc;
	logic [16:0] env_acc;

	pcs_result_t expected_samples [$];
	pcs_result_t want;
	pcs_result_t fresh;
	pcs_item_t   word;
	int          mism;
	int          n_checked;
	int          n_writes;
	int          n_ticks;
	int          n_len;
	int          n_sweep;

	// Add elapsed ticks to a timer, holding at the top of its range
	function automatic logic [16:0] tick_sum(input logic [16:0] acc, input logic [7:0] d);
		logic [17:0] total;
		total = {1'b0, acc} + 18'(d);
		return (total > 18'(ACC_MAX)) ? ACC_MAX : total[16:0];
	endfunction

	// Print one line per mismatch (up to a cap) and count it
	task automatic report_mismatch(input string msg);
		if (mism < PRINT_CAP)
			$display("checker: mismatch at result %0d: %s", n_checked, msg);
		mism++;
	endtask

	// Apply one input word to the channel copy and form the status after it
	task automatic predict_sample(input pcs_item_t w, output pcs_result_t r);
		logic [16:0] span;
		logic [11:0] sum;
		logic [10:0] off;
		logic        halted;
		logic        bit_now;
		halted = 1'b0;
		if (w.action == ACT_WRITE) begin
			if (w.reg_index < NUM_REGS) begin
				n_writes++;
				chan_bytes[w.reg_index] = w.write_data;
				// the trigger bit stays stored, so every write retriggers while set
				if (chan_bytes[REG_FREQ_HI][7]) begin
					on = 1'b1;
					step = '0;
					len_acc = '0;
					sw_acc = '0;
					duty_acc = '0;
					env_acc = '0;
					vol = chan_bytes[REG_ENV][7:4];
				end
				case (chan_bytes[REG_DUTY_LEN][7:6])
					2'd0: wave = 8'h01;
					2'd1: wave = 8'h03;
					2'd2: wave = 8'h0F;
					default: wave = 8'hFC;
				endcase
				len_en = chan_bytes[REG_FREQ_HI][6];
				// length always reloads from the byte on every channel write
				len_cnt = {1'b0, chan_bytes[REG_DUTY_LEN][5:0]};
				env_up = chan_bytes[REG_ENV][3];
				env_rate = chan_bytes[REG_ENV][2:0];
				sw_pace = chan_bytes[REG_SWEEP][6:4];
				sw_down = chan_bytes[REG_SWEEP][3];
				sw_shift = chan_bytes[REG_SWEEP][2:0];
				freq = {chan_bytes[REG_FREQ_HI][2:0], chan_bytes[REG_FREQ_LO]};
			end
		end else begin
			n_ticks++;
			if (master_on && on) begin
				// length timer; expiry stops the channel and skips the rest
				if (len_en) begin
					len_acc = tick_sum(len_acc, w.tick_cycles);
					if (len_acc >= LEN_TICKS) begin
						len_acc = len_acc - LEN_TICKS;
						len_cnt = len_cnt + 7'd1;
						if (len_cnt >= LEN_LIMIT) begin
							on = 1'b0;
							halted = 1'b1;
							n_len++;
						end
					end
				end
				// sweep timer; overflow upward pins the frequency and stops
				if (!halted && sw_pace != 3'd0) begin
					sw_acc = tick_sum(sw_acc, w.tick_cycles);
					span = 17'(sw_pace) * SWEEP_UNIT;
					if (sw_acc >= span) begin
						off = freq >> sw_shift;
						sw_acc = sw_acc - span;
						if (sw_down) begin
							freq = freq - off;
						end else begin
							sum = {1'b0, freq} + {1'b0, off};
							if (sum > FREQ_MAX) begin
								freq = FREQ_MAX[10:0];
								on = 1'b0;
								halted = 1'b1;
								n_sweep++;
							end else begin
								freq = sum[10:0];
							end
						end
					end
				end
				// duty timer, one step at most per word
				if (!halted) begin
					duty_acc = tick_sum(duty_acc, w.tick_cycles);
					span = {5'b0, DUTY_SPAN - {1'b0, freq}};
					if (duty_acc >= span) begin
						duty_acc = duty_acc - span;
						step = step + 3'd1;
					end
				end
				// envelope timer, volume held at both ends
				if (!halted && env_rate != 3'd0) begin
					env_acc = tick_sum(env_acc, w.tick_cycles);
					span = 17'(env_rate) * ENV_UNIT;
					if (env_acc >= span) begin
						env_acc = env_acc - span;
						if (!env_up && vol != 4'd0)
							vol = vol - 4'd1;
						else if (env_up && vol != VOL_MAX)
							vol = vol + 4'd1;
					end
				end
			end
		end
		bit_now = wave[step];
		r.channel_on = on;
		r.duty_bit = bit_now;
		r.level = (on && bit_now) ? vol : 4'd0;
		r.duty_position = step;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_on = 1'b0;
			for (int i = 0; i < NUM_REGS; i++)
				chan_bytes[i] = 8'h00;
			on = 1'b0;
			wave = '0;
			step = '0;
			vol = '0;
			len_cnt = '0;
			len_en = 1'b0;
			env_up = 1'b0;
			env_rate = '0;
			sw_pace = '0;
			sw_down = 1'b0;
			sw_shift = '0;
			freq = '0;
			len_acc = '0;
			sw_acc = '0;
			duty_acc = '0;
			env_acc = '0;
			expected_samples.delete();
			mism = 0;
			n_checked = 0;
			n_writes = 0;
			n_ticks = 0;
			n_len = 0;
			n_sweep = 0;
		end else begin
			// compare a delivered result word with the oldest expectation
			if (sample.valid && sample.ready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_samples.pop_front();
					if (sample.channel_on !== want.channel_on)
						report_mismatch($sformatf("channel_on got %b expected %b",
							sample.channel_on, want.channel_on));
					if (sample.duty_bit !== want.duty_bit)
						report_mismatch($sformatf("duty_bit got %b expected %b",
							sample.duty_bit, want.duty_bit));
					if (sample.level !== want.level)
						report_mismatch($sformatf("level got %0d expected %0d",
							sample.level, want.level));
					if (sample.duty_position !== want.duty_position)
						report_mismatch($sformatf("duty_position got %0d expected %0d",
							sample.duty_position, want.duty_position));
				end
				n_checked++;
			end
			// track the master enable register
			if (psel && penable && pwrite && pready && paddr == {CFG_MASTER_ENABLE, 2'b00})
				master_on = pwdata[0];
			// predict the result of each accepted input word
			if (cmd.valid && cmd.ready) begin
				word = {cmd.action, cmd.tick_cycles, cmd.reg_index, cmd.write_data};
				predict_sample(word, fresh);
				expected_samples.push_back(fresh);
			end
		end
		errors <= mism;
		outstanding <= expected_samples.size();
		checked <= n_checked;
		writes_seen <= n_writes;
		ticks_seen <= n_ticks;
		length_stops <= n_len;
		sweep_stops <= n_sweep;
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
	import pcs_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          HOLD_CYCLES = 300;
	localparam logic [2:0]  REG_VOID_LO = 3'd5;
	localparam logic [2:0]  REG_VOID_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic        src_gaps = 1'b0;
	logic        sink_gaps = 1'b0;
	logic        hold_req = 1'b0;
	int unsigned sink_idle;
	int unsigned cycles = 0;
	int unsigned sent = 0;

	int errors;
	int outstanding;
	int checked;
	int writes_seen;
	int ticks_seen;
	int length_stops;
	int sweep_stops;

	pcs_cmd_if    cmd_ch ();
	pcs_sample_if res_ch ();

	pulse_channel_with_sweep dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.sample  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pcs_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.sample       (res_ch),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.errors       (errors),
		.outstanding  (outstanding),
		.checked      (checked),
		.writes_seen  (writes_seen),
		.ticks_seen   (ticks_seen),
		.length_stops (length_stops),
		.sweep_stops  (sweep_stops)
	);

	always #6 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Result receiver: random stalls, or one long hold-off on request
	initial begin
		sink_idle = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				sink_idle = HOLD_CYCLES;
			end else if (sink_idle == 0 && sink_gaps && $urandom_range(0, 5) == 0) begin
				sink_idle = $urandom_range(1, 8);
			end
			if (sink_idle != 0) begin
				res_ch.ready <= 1'b0;
				sink_idle--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one word, with an optional idle burst first; call at a falling edge
	task automatic send_word(input logic act, input logic [7:0] ticks,
		input logic [2:0] idx, input logic [7:0] data);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.tick_cycles <= ticks;
		cmd_ch.reg_index <= idx;
		cmd_ch.write_data <= data;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
		if (!(act == ACT_WRITE && idx >= NUM_REGS))
			sent++;
	endtask

	task automatic tick_word(input logic [7:0] n);
		send_word(ACT_TICK, n, 3'($urandom), 8'($urandom));
	endtask

	task automatic write_word(input logic [2:0] idx, input logic [7:0] data);
		send_word(ACT_WRITE, 8'($urandom), idx, data);
	endtask

	// Drop valid and wait until every expected result word has arrived
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Write the master enable register through a setup and an access cycle
	task automatic apb_write(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {CFG_MASTER_ENABLE, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly programmed channels run through tick bursts, with some raw noise
	task automatic run_random(input int unsigned words, input logic vary_gaps);
		int unsigned stop_at;
		int unsigned burst;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [7:0]  b4;
		stop_at = sent + words;
		while (sent < stop_at) begin
			if (vary_gaps) begin
				src_gaps = $urandom_range(0, 3) != 0;
				sink_gaps = $urandom_range(0, 3) != 0;
			end
			if ($urandom_range(0, 3) != 0) begin
				// bias toward timers that fire within a burst
				b0 = 8'($urandom);
				if ($urandom_range(0, 2) != 0)
					b0[6:4] = 3'($urandom_range(1, 2));
				b1 = 8'($urandom);
				if ($urandom_range(0, 2) == 0)
					b1[5:2] = 4'hF;
				b2 = 8'($urandom);
				if ($urandom_range(0, 2) != 0)
					b2[2:0] = 3'($urandom_range(0, 1));
				if ($urandom_range(0, 3) == 0)
					b2[7:4] = b2[3] ? VOL_MAX : 4'd0;
				b3 = 8'($urandom);
				b4 = 8'($urandom);
				b4[7] = 1'b1;
				write_word(REG_SWEEP, b0);
				write_word(REG_DUTY_LEN, b1);
				write_word(REG_ENV, b2);
				write_word(REG_FREQ_LO, b3);
				write_word(REG_FREQ_HI, b4);
				// sometimes clear the stored trigger so later writes leave timers alone
				if ($urandom_range(0, 1) == 0) begin
					b4[7] = 1'b0;
					write_word(REG_FREQ_HI, b4);
				end
				burst = $urandom_range(10, 150);
				repeat (burst) begin
					if ($urandom_range(0, 24) == 0)
						write_word(3'($urandom_range(0, 4)), 8'($urandom));
					else if ($urandom_range(0, 3) != 0)
						tick_word(8'($urandom_range(160, 255)));
					else
						tick_word(8'($urandom));
				end
			end else begin
				repeat ($urandom_range(5, 20))
					send_word(1'($urandom), 8'($urandom), 3'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ACT_TICK;
		cmd_ch.tick_cycles = '0;
		cmd_ch.reg_index = '0;
		cmd_ch.write_data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// master off: a trigger still enables, ticks change nothing
		apb_write(32'd0);
		tick_word(8'd255);
		write_word(REG_FREQ_HI, 8'h80);
		tick_word(8'd255);
		write_word(REG_VOID_HI, 8'hFF);
		write_word(REG_VOID_LO, 8'h00);
		drain();
		apb_write(32'd1);

		// highest frequency: one duty step per tick word with a nonzero tick count
		write_word(REG_SWEEP, 8'h00);
		write_word(REG_DUTY_LEN, 8'hC0);
		write_word(REG_ENV, 8'hF0);
		write_word(REG_FREQ_LO, 8'hFF);
		write_word(REG_FREQ_HI, 8'h87);
		tick_word(8'd0);
		tick_word(8'd1);
		tick_word(8'd255);
		tick_word(8'd255);

		// length expiry from a count of 63, then ticks while off
		write_word(REG_DUTY_LEN, 8'h3F);
		write_word(REG_FREQ_HI, 8'hC7);
		repeat (17) tick_word(8'd255);
		tick_word(8'd255);

		// sweep up past the top of the frequency range
		write_word(REG_FREQ_HI, 8'h07);
		write_word(REG_SWEEP, 8'h11);
		write_word(REG_FREQ_LO, 8'h00);
		write_word(REG_FREQ_HI, 8'h86);
		repeat (33) tick_word(8'd255);
		write_word(REG_FREQ_HI, 8'h00);
		drain();

		// random traffic; the receiver holds off at the start to fill the block
		hold_req = 1'b1;
		run_random(600, 1'b1);
		drain();
		apb_write(32'd0);
		run_random(300, 1'b1);
		drain();
		apb_write(32'd1);
		run_random(700, 1'b1);

		// final stretch with no idling on either side
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		run_random(200, 1'b0);
		drain();
		repeat (4) @(posedge clk);

		$display("tb: %0d result words checked over %0d register writes and %0d tick words",
			checked, writes_seen, ticks_seen);
		$display("tb: channel stopped %0d times by length expiry, %0d by sweep overflow",
			length_stops, sweep_stops);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
